// ===== rtl/blst_pkg.sv =====
// ---------------------------------------------------------------------------
// blst_pkg
// Shared types for the line stepper: walker state codes, queue status and
// the queue depth between the segment front end and the point walker.
// ---------------------------------------------------------------------------
package blst_pkg;

    // Entries held between the front end and the walker (power of two)
    localparam int QUEUE_DEPTH = 2;

    // Walker state, one-hot
    typedef enum logic [1:0] {
        WALK_IDLE = 2'b01,
        WALK_RUN  = 2'b10
    } t_walk_state;

    // Fill status that the segment queue reports to both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// ===== rtl/blst_if.sv =====
// ---------------------------------------------------------------------------
// blst_if
// Valid/ready channels of the line stepper: the segment input channel and
// the pixel point output channel.
// ---------------------------------------------------------------------------
interface blst_seg_if #(
    parameter int COORD_BITS = 6
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;

    modport source (output valid, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, x_start, y_start, x_end, y_end, output ready);
endinterface

interface blst_pt_if #(
    parameter int COORD_BITS = 6
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

// ===== rtl/blst_front.sv =====
// ---------------------------------------------------------------------------
// blst_front
// Segment front end: takes a segment, classifies it (walk or single point)
// and computes the initial decision term and both term increments.
// ---------------------------------------------------------------------------
module blst_front
    import blst_pkg::*;
#(
    parameter int COORD_BITS = 6
) (
    blst_seg_if.sink                        i_seg,
    input  t_queue_status                   i_status,
    output logic                            o_push,
    output logic [6*COORD_BITS+12-1:0]      o_entry
);

    localparam int DEC_BITS = COORD_BITS + 4;

    logic                       backward;
    logic [COORD_BITS-1:0]      x_end_adj;
    logic [COORD_BITS-1:0]      delta_x;
    logic signed [DEC_BITS-1:0] delta_x_ext;
    logic signed [DEC_BITS-1:0] delta_y_ext;
    logic signed [DEC_BITS-1:0] dec_init;
    logic signed [DEC_BITS-1:0] inc_keep;
    logic signed [DEC_BITS-1:0] inc_step;

    // Accept whenever the queue has room
    assign i_seg.ready = ~i_status.full;
    assign o_push      = i_seg.valid & ~i_status.full;

    // Classify: an end x at or below the start x gives only the start point
    assign backward  = (i_seg.x_end <= i_seg.x_start);
    assign x_end_adj = backward ? i_seg.x_start : i_seg.x_end;
    assign delta_x   = backward ? '0 : (i_seg.x_end - i_seg.x_start);

    // Decision term setup: 2*dy - dx, increments 2*dy and 2*(dy - dx)
    assign delta_x_ext = signed'({{4{1'b0}}, delta_x});
    assign delta_y_ext = signed'({{4{1'b0}}, i_seg.y_end})
                       - signed'({{4{1'b0}}, i_seg.y_start});
    assign inc_keep    = delta_y_ext <<< 1;
    assign dec_init    = inc_keep - delta_x_ext;
    assign inc_step    = (delta_y_ext - delta_x_ext) <<< 1;

    assign o_entry = {i_seg.x_start, i_seg.y_start, x_end_adj,
                      dec_init, inc_keep, inc_step};

endmodule

// ===== rtl/blst_queue.sv =====
// ---------------------------------------------------------------------------
// blst_queue
// Short first-in first-out queue of classified segments between the front
// end and the walker.
// ---------------------------------------------------------------------------
module blst_queue
    import blst_pkg::*;
#(
    parameter int DATA_BITS = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [DATA_BITS-1:0] i_data,
    input  logic                 i_pop,
    output logic [DATA_BITS-1:0] o_data,
    output t_queue_status        o_status
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_BITS-1:0] r_slot [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  r_wptr;
    logic [PTR_BITS-1:0]  r_rptr;
    logic [CNT_BITS-1:0]  r_count;
    logic [CNT_BITS-1:0]  n_count;

    assign o_status.full  = (r_count == CNT_BITS'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_data         = r_slot[r_rptr];

    // Track fill level
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

endmodule

// ===== rtl/blst_back.sv =====
// ---------------------------------------------------------------------------
// blst_back
// Point walker: pops a classified segment, steps x by one per point, steps
// y by the sign of the saturating decision term and drives the output
// register.
// ---------------------------------------------------------------------------
module blst_back
    import blst_pkg::*;
#(
    parameter int COORD_BITS = 6
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_queue_status                   i_status,
    input  logic [6*COORD_BITS+12-1:0]      i_entry,
    output logic                            o_pop,
    blst_pt_if.source                       o_pt
);

    localparam int DEC_BITS = COORD_BITS + 4;
    localparam int SUM_BITS = DEC_BITS + 1;

    t_walk_state                r_state;
    t_walk_state                n_state;
    logic [COORD_BITS-1:0]      r_x;
    logic [COORD_BITS-1:0]      r_y;
    logic [COORD_BITS-1:0]      r_xe;
    logic signed [DEC_BITS-1:0] r_dec;
    logic signed [DEC_BITS-1:0] r_keep;
    logic signed [DEC_BITS-1:0] r_step;
    logic                       r_out_valid;
    logic [COORD_BITS-1:0]      r_out_x;
    logic [COORD_BITS-1:0]      r_out_y;
    logic                       r_out_last;

    logic [COORD_BITS-1:0]      e_xs;
    logic [COORD_BITS-1:0]      e_ys;
    logic [COORD_BITS-1:0]      e_xe;
    logic signed [DEC_BITS-1:0] e_dec;
    logic signed [DEC_BITS-1:0] e_keep;
    logic signed [DEC_BITS-1:0] e_step;
    logic                       can_emit;
    logic                       emit;
    logic                       is_last;
    logic signed [DEC_BITS-1:0] add_val;
    logic signed [SUM_BITS-1:0] dec_sum;
    logic signed [DEC_BITS-1:0] dec_next;

    assign {e_xs, e_ys, e_xe, e_dec, e_keep, e_step} = i_entry;

    // Output register frees when empty or taken this cycle
    assign can_emit = ~r_out_valid | o_pt.ready;
    assign emit     = (r_state == WALK_RUN) & can_emit;
    assign is_last  = (r_x == r_xe);
    assign o_pop    = (r_state == WALK_IDLE) & ~i_status.empty;

    // Decision update with saturation at the signed term width
    assign add_val = r_dec[DEC_BITS-1] ? r_keep : r_step;
    assign dec_sum = SUM_BITS'(r_dec) + SUM_BITS'(add_val);
    always_comb begin
        if (dec_sum[SUM_BITS-1] != dec_sum[SUM_BITS-2]) begin
            dec_next = {dec_sum[SUM_BITS-1], {(DEC_BITS-1){~dec_sum[SUM_BITS-1]}}};
        end else begin
            dec_next = dec_sum[DEC_BITS-1:0];
        end
    end

    // Walker state
    always_comb begin
        n_state = r_state;
        case (r_state)
            WALK_IDLE: begin
                if (o_pop) begin
                    n_state = WALK_RUN;
                end
            end
            WALK_RUN: begin
                if (emit && is_last) begin
                    n_state = WALK_IDLE;
                end
            end
            default: n_state = WALK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= WALK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_pt.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load a segment, then advance one point per transfer slot
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_x    <= e_xs;
            r_y    <= e_ys;
            r_xe   <= e_xe;
            r_dec  <= e_dec;
            r_keep <= e_keep;
            r_step <= e_step;
        end else if (emit) begin
            r_x   <= r_x + 1'b1;
            r_dec <= dec_next;
            if (!r_dec[DEC_BITS-1]) begin
                r_y <= r_y + 1'b1;
            end
        end
    end

    // Hold the point until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_x    <= r_x;
            r_out_y    <= r_y;
            r_out_last <= is_last;
        end
    end

    assign o_pt.valid      = r_out_valid;
    assign o_pt.point_x    = r_out_x;
    assign o_pt.point_y    = r_out_y;
    assign o_pt.last_point = r_out_last;

endmodule

// ===== rtl/bresenham_line_stepper.sv =====
// ---------------------------------------------------------------------------
// bresenham_line_stepper
// First-octant Bresenham line stepper: one segment in, a run of points out.
// ---------------------------------------------------------------------------
// Usage:
//   i_seg carries one segment (x_start, y_start, x_end, y_end) per transfer.
//   o_pt carries the pixel points from start to end, one per transfer, with
//   last_point set on the final one. An end x at or below the start x gives
//   only the start point, flagged last. y wraps at the coordinate width.
//   Segments enter a two-entry queue, so the input keeps taking segments
//   while the walker is busy, until the queue is full.
//   Throughput: one point per cycle while the receiver takes them; each
//   segment gives (x_end - x_start + 1) points once the walker has loaded it
//   from the queue, and the next segment is loaded only after its last point.
//   When the walker is idle, the first point of a segment passes the queue,
//   the walker load and the output register in that order.
//   A stalled receiver holds the output register and freezes the walker;
//   the input stalls once the queue fills.
//   Reset (i_rst_n low, synchronous) empties the queue, idles the walker
//   and drops the output valid.
// ---------------------------------------------------------------------------
module bresenham_line_stepper
    import blst_pkg::*;
#(
    parameter int COORD_BITS = 6
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    blst_seg_if.sink  i_seg,
    blst_pt_if.source o_pt
);

    localparam int ENTRY_BITS = 6 * COORD_BITS + 12;

    t_queue_status         status;
    logic                  push;
    logic                  pop;
    logic [ENTRY_BITS-1:0] push_entry;
    logic [ENTRY_BITS-1:0] head_entry;

    // Classify and set up each segment
    blst_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_seg    (i_seg),
        .i_status (status),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    // Decouple the front end from the walker
    blst_queue #(
        .DATA_BITS (ENTRY_BITS)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_entry),
        .i_pop    (pop),
        .o_data   (head_entry),
        .o_status (status)
    );

    // Walk the points
    blst_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .i_entry  (head_entry),
        .o_pop    (pop),
        .o_pt     (o_pt)
    );

endmodule

// ===== tb/bresenham_line_stepper_tb.sv =====
// ---------------------------------------------------------------------------
// bresenham_line_stepper_tb
// Self-checking bench for the line stepper. A directed burst covers the
// corners, the flat, steep and falling slopes, single-point segments and
// the decision-term limits. A random run of short, long and degenerate
// segments follows. Both channels take random gaps and stalls. Each
// accepted segment is expanded into the expected pixel run, and every
// point transfer is checked against it in order.
// ---------------------------------------------------------------------------
module bresenham_line_stepper_tb;

    localparam int COORD_BITS  = 6;
    localparam int DEC_BITS    = COORD_BITS + 4;
    localparam int DEC_MAX     = (1 << (DEC_BITS - 1)) - 1;
    localparam int DEC_MIN     = -DEC_MAX - 1;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int RANDOM_SEGS = 153;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 20;

    typedef logic [COORD_BITS-1:0] t_coord;

    // Expected pixel run of every accepted segment, checked in order
    class point_scoreboard;
        typedef struct {
            t_coord px;
            t_coord py;
            logic   last;
        } t_point;

        t_point pending_points[$];
        int     errors;

        function new();
            errors = 0;
        endfunction

        // Keep the decision term inside its signed register width
        function int clamp_term(int v);
            if (v > DEC_MAX) return DEC_MAX;
            if (v < DEC_MIN) return DEC_MIN;
            return v;
        endfunction

        // Walk one segment and queue every pixel it must produce
        function void note_segment(t_coord xs, t_coord ys, t_coord xe, t_coord ye);
            t_point p;
            t_coord cx;
            t_coord cy;
            int     term;
            int     dx;
            int     dy;
            cx = xs;
            cy = ys;
            dy = int'(ye) - int'(ys);
            // end at or below start: the start point alone, flagged last
            if (xe <= xs) begin
                p = '{cx, cy, 1'b1};
                pending_points.push_back(p);
                return;
            end
            dx   = int'(xe) - int'(xs);
            term = clamp_term(2 * dy - dx);
            p    = '{cx, cy, 1'b0};
            pending_points.push_back(p);
            while (cx != xe) begin
                cx = cx + 1'b1;
                if (term < 0) begin
                    term = clamp_term(term + 2 * dy);
                end else begin
                    cy   = cy + 1'b1;
                    term = clamp_term(term + 2 * (dy - dx));
                end
                p = '{cx, cy, cx == xe};
                pending_points.push_back(p);
            end
        endfunction

        // Compare one point transfer with the oldest expected point
        function void check_point(t_coord px, t_coord py, logic last);
            t_point e;
            if (pending_points.size() == 0) begin
                $error("unexpected point x=%0d y=%0d last=%0b", px, py, last);
                errors++;
                return;
            end
            e = pending_points.pop_front();
            if (px !== e.px) begin
                $error("point_x: expected %0d, got %0d", e.px, px);
                errors++;
            end
            if (py !== e.py) begin
                $error("point_y: expected %0d, got %0d", e.py, py);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_point: expected %0b, got %0b", e.last, last);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_points.size();
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    int              cycle_count = 0;
    bit              sender_steady;
    int              points_seen;
    point_scoreboard board;

    blst_seg_if #(.COORD_BITS(COORD_BITS)) seg_ch ();
    blst_pt_if  #(.COORD_BITS(COORD_BITS)) pt_ch ();

    bresenham_line_stepper #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_seg  (seg_ch.sink),
        .o_pt   (pt_ch.source)
    );

    // Clock, 12 units per period
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Hold the segment channel for one transfer after a random gap
    task automatic send_segment(t_coord xs, t_coord ys, t_coord xe, t_coord ye);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            seg_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        seg_ch.valid   <= 1'b1;
        seg_ch.x_start <= xs;
        seg_ch.y_start <= ys;
        seg_ch.x_end   <= xe;
        seg_ch.y_end   <= ye;
        do @(posedge i_clk); while (!seg_ch.ready);
        board.note_segment(xs, ys, xe, ye);
    endtask

    // Drop valid and wait until every queued point has been checked
    task automatic drain_points();
        seg_ch.valid <= 1'b0;
        do @(posedge i_clk); while (board.outstanding() != 0);
    endtask

    // Mostly short rising runs, some with a random end, some full-width ones, some degenerate ones
    task automatic send_random_segment();
        t_coord xs;
        t_coord xe;
        t_coord ys;
        t_coord ye;
        int     pick;
        pick = $urandom_range(0, 99);
        xs   = t_coord'($urandom_range(0, COORD_MAX));
        if (pick < 65) begin
            xs = t_coord'($urandom_range(0, COORD_MAX - 1));
            xe = xs + t_coord'($urandom_range(1,
                     (COORD_MAX - xs < 15) ? COORD_MAX - xs : 15));
        end else if (pick < 80) begin
            xe = t_coord'($urandom_range(0, COORD_MAX));
        end else if (pick < 88) begin
            xs = t_coord'($urandom_range(0, 3));
            xe = t_coord'($urandom_range(COORD_MAX - 3, COORD_MAX));
        end else begin
            xe = t_coord'($urandom_range(0, xs));
        end
        ys = t_coord'($urandom_range(0, COORD_MAX));
        ye = t_coord'($urandom_range(0, COORD_MAX));
        send_segment(xs, ys, xe, ye);
    endtask

    // Point receiver: random stalls, with stretches that take every point
    initial begin
        int stall;
        pt_ch.ready = 1'b0;
        points_seen = 0;
        @(posedge i_rst_n);
        forever begin
            stall = ((points_seen / 90) % 3 == 1) ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                pt_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pt_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!pt_ch.valid);
            board.check_point(pt_ch.point_x, pt_ch.point_y, pt_ch.last_point);
            points_seen++;
        end
    end

    // Stimulus
    initial begin
        board          = new();
        sender_steady  = 1'b0;
        seg_ch.valid   = 1'b0;
        seg_ch.x_start = '0;
        seg_ch.y_start = '0;
        seg_ch.x_end   = '0;
        seg_ch.y_end   = '0;
        i_rst_n        = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corners and full-width diagonals
        send_segment(6'd0, 6'd0, 6'd63, 6'd63);
        send_segment(6'd0, 6'd63, 6'd63, 6'd0);
        send_segment(6'd0, 6'd0, 6'd63, 6'd0);
        send_segment(6'd0, 6'd63, 6'd63, 6'd63);
        send_segment(6'd63, 6'd63, 6'd63, 6'd63);
        send_segment(6'd0, 6'd0, 6'd0, 6'd0);
        // Single point: equal x, then end x below start x
        send_segment(6'd21, 6'd9, 6'd21, 6'd40);
        send_segment(6'd63, 6'd0, 6'd0, 6'd63);
        send_segment(6'd40, 6'd33, 6'd12, 6'd2);
        // Shallow, one-step and steep slopes
        send_segment(6'd3, 6'd10, 6'd50, 6'd22);
        send_segment(6'd62, 6'd0, 6'd63, 6'd63);
        send_segment(6'd0, 6'd55, 6'd5, 6'd63);
        // Decision term driven into both limits
        send_segment(6'd0, 6'd0, 6'd30, 6'd63);
        send_segment(6'd10, 6'd63, 6'd60, 6'd0);
        // Falling slope, one-below-start and a short steep run
        send_segment(6'd20, 6'd30, 6'd35, 6'd25);
        send_segment(6'd1, 6'd62, 6'd0, 6'd1);
        send_segment(6'd42, 6'd21, 6'd47, 6'd42);

        // Hold off until the walker has flushed everything
        drain_points();

        for (int n = 0; n < RANDOM_SEGS; n++) begin
            sender_steady = (n >= 40 && n < 70) || (n >= 130 && n < 145);
            if (n == 100) drain_points();
            send_random_segment();
        end
        seg_ch.valid <= 1'b0;

        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
